[hw/rtl/obd_pkg.sv]
// Shared types, register indexes and Bayer threshold tables for the ordered
// Bayer dither block. No dependencies; every other file imports this package.
package obd_pkg;

	// Default for the largest supported image width.
	localparam int MAX_WIDTH_DEF = 4096;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREYSCALE   = 2'd2;

	// Matrix size codes; the unused code falls back to the 4x4 table.
	localparam logic [1:0] SIZE_2X2 = 2'd0;
	localparam logic [1:0] SIZE_4X4 = 2'd1;
	localparam logic [1:0] SIZE_8X8 = 2'd2;

	// Register reset values.
	localparam logic [1:0]            MATRIX_SIZE_RST = SIZE_4X4;
	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST = 13'd640;
	localparam logic                  GREYSCALE_RST   = 1'b1;

	// Largest table entry for each matrix size.
	localparam logic [5:0] MAX_ENTRY_2X2 = 6'd3;
	localparam logic [5:0] MAX_ENTRY_4X4 = 6'd15;
	localparam logic [5:0] MAX_ENTRY_8X8 = 6'd63;

	// Grey weights in 16-bit fraction; they sum to exactly 65536.
	localparam logic [16:0] GREY_WT_R = 17'd19595;
	localparam logic [16:0] GREY_WT_G = 17'd38470;
	localparam logic [16:0] GREY_WT_B = 17'd7471;

	// Bayer tables, row major.
	localparam logic [5:0] BAYER2 [4] = '{6'd0, 6'd2, 6'd3, 6'd1};

	localparam logic [5:0] BAYER4 [16] = '{
		6'd0,  6'd8,  6'd2,  6'd10,
		6'd12, 6'd4,  6'd14, 6'd6,
		6'd3,  6'd11, 6'd1,  6'd9,
		6'd15, 6'd7,  6'd13, 6'd5
	};

	localparam logic [5:0] BAYER8 [64] = '{
		6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
		6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
		6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
		6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
		6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
		6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
		6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
		6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
	};

	// One input pixel.
	typedef struct packed {
		logic       start_of_image;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	// One dithered pixel.
	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} res_t;

	// Settings the position tracker needs.
	typedef struct packed {
		logic [1:0]            size_sel;
		logic [CFG_DATA_W-1:0] width;
	} pos_cfg_t;

	// Threshold picked for one pixel.
	typedef struct packed {
		logic [5:0] entry;
		logic [5:0] max_entry;
	} thr_t;

	// Grey or original colour values of one pixel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

endpackage

[hw/rtl/obd_if.sv]
// Valid/ready stream interfaces for the pixel input and the dithered output.
// Depends on obd_pkg for the payload types.
interface obd_pix_if
	import obd_pkg::*;
();
	logic valid;
	logic ready;
	pix_t pix;

	modport source (output valid, output pix, input ready);
	modport sink (input valid, input pix, output ready);
endinterface

interface obd_res_if
	import obd_pkg::*;
();
	logic valid;
	logic ready;
	res_t res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

[hw/rtl/ordered_bayer_dither.sv]
// Ordered Bayer dither top level: config registers, three-stage pipeline.
// Depends on obd_pkg, obd_if, obd_pos, obd_grey and obd_cmp.
//
// Takes one pixel per clock in raster order and returns one dithered pixel
// per clock: an input stage holds the pixel
// and its Bayer threshold, a second stage holds the grey or original colour
// values, and the output register holds the result. The whole pipeline
// advances together and stops only while a result waits at the output, so
// pixel.ready follows result.ready whenever a result is held. Position
// tracking restarts at the origin on a start-of-image mark and wraps rows at
// image_width. Write configuration only while no pixel is in flight.
module ordered_bayer_dither
	import obd_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	obd_pix_if.sink               pixel,
	obd_res_if.source             result
);

	logic [1:0]            size_sel_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic                  grey_en_q;

	logic     adv;
	logic     accept;
	pos_cfg_t pos_cfg;
	thr_t     thr;

	logic       v_s1;
	rgb_t       rgb_s1;
	logic [7:0] alpha_s1;
	thr_t       thr_s1;

	rgb_t       rgb_grey;
	logic       v_s2;
	rgb_t       rgb_s2;
	logic [7:0] alpha_s2;
	thr_t       thr_s2;

	res_t res_next;
	logic out_valid_q;
	res_t res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_sel_q <= MATRIX_SIZE_RST;
			width_q    <= IMAGE_WIDTH_RST;
			grey_en_q  <= GREYSCALE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MATRIX_SIZE: size_sel_q <= wr_data[1:0];
				REG_IMAGE_WIDTH: width_q    <= wr_data;
				REG_GREYSCALE:   grey_en_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is free or being read.
	assign adv          = !out_valid_q || result.ready;
	assign pixel.ready  = adv;
	assign accept       = pixel.valid && adv;
	assign result.valid = out_valid_q;
	assign result.res   = res_q;

	// Position and threshold for the item being accepted.
	assign pos_cfg = '{size_sel: size_sel_q, width: width_q};

	obd_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.sof   (pixel.pix.start_of_image),
		.cfg   (pos_cfg),
		.thr   (thr)
	);

	// Greyscale between the input stage and the second stage.
	obd_grey u_grey (
		.enable (grey_en_q),
		.rgb_in (rgb_s1),
		.rgb_out(rgb_grey)
	);

	// One compare per colour channel; alpha passes through.
	obd_cmp u_cmp_r (.value(rgb_s2.red),   .thr(thr_s2), .level(res_next.out_red));
	obd_cmp u_cmp_g (.value(rgb_s2.green), .thr(thr_s2), .level(res_next.out_green));
	obd_cmp u_cmp_b (.value(rgb_s2.blue),  .thr(thr_s2), .level(res_next.out_blue));
	assign res_next.out_alpha = alpha_s2;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pixel.valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s1   <= '{red: pixel.pix.red, green: pixel.pix.green,
				blue: pixel.pix.blue};
			alpha_s1 <= pixel.pix.alpha;
			thr_s1   <= thr;
			rgb_s2   <= rgb_grey;
			alpha_s2 <= alpha_s1;
			thr_s2   <= thr_s1;
			res_q    <= res_next;
		end
	end

`ifndef NO_ASSERTIONS
	// A held result must stall the input side.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pixel.ready)
		else $error("input taken while output stalled");

	// An accepted item reaches the input stage.
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> v_s1)
		else $error("accepted item lost");

	// Dithered red and blue channels are saturated.
	a_binary: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.res.out_red == 8'd0 || result.res.out_red == 8'd255)
			&& (result.res.out_blue == 8'd0 || result.res.out_blue == 8'd255))
		else $error("channel not binary");

	// In grey mode all colour channels agree.
	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && grey_en_q |-> result.res.out_red == result.res.out_green
			&& result.res.out_green == result.res.out_blue)
		else $error("grey channels differ");
`endif

endmodule

[hw/rtl/obd_pos.sv]
// Column and row-phase tracker with Bayer threshold lookup.
// Depends on obd_pkg for tables, size codes and the config struct.
module obd_pos
	import obd_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  logic     sof,
	input  pos_cfg_t cfg,
	output thr_t     thr
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = COL_W + 1;

	logic [COL_W-1:0] col_q;
	logic [2:0]       row_q;
	logic [COL_W-1:0] col_use;
	logic [2:0]       row_use;
	logic [WID_W-1:0] width_eff;
	logic [WID_W-1:0] col_inc;
	logic             wrap;

	// A start mark puts the pixel at the origin whatever the state holds.
	assign col_use = sof ? '0 : col_q;
	assign row_use = sof ? '0 : row_q;

	// Clamp the row width to what the counter can hold. Width zero needs no
	// special case: every pixel then ends a row, as with width one.
	always_comb begin
		if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
			width_eff = WID_W'(MAX_WIDTH);
		end else begin
			width_eff = WID_W'(cfg.width);
		end
	end

	assign col_inc = WID_W'(col_use) + WID_W'(1);
	assign wrap    = (col_inc >= width_eff);

	// Position advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= row_use + 3'd1;
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_use;
			end
		end
	end

	// Threshold lookup at (row mod size, column mod size).
	always_comb begin
		unique case (cfg.size_sel)
			SIZE_2X2: begin
				thr.entry     = BAYER2[{row_use[0], col_use[0]}];
				thr.max_entry = MAX_ENTRY_2X2;
			end
			SIZE_8X8: begin
				thr.entry     = BAYER8[{row_use, col_use[2:0]}];
				thr.max_entry = MAX_ENTRY_8X8;
			end
			default: begin
				thr.entry     = BAYER4[{row_use[1:0], col_use[1:0]}];
				thr.max_entry = MAX_ENTRY_4X4;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// The column counter never reaches the largest width.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(MAX_WIDTH))
		else $error("column counter out of range");
`endif

endmodule

[hw/rtl/obd_grey.sv]
// Optional weighted greyscale conversion of one pixel.
// Depends on obd_pkg for the weights and the colour struct.
module obd_grey
	import obd_pkg::*;
(
	input  logic enable,
	input  rgb_t rgb_in,
	output rgb_t rgb_out
);

	logic [24:0] sum;
	logic [7:0]  grey;

	// Weighted sum in 16-bit fraction, truncated; it never exceeds 255.
	assign sum = 25'(GREY_WT_R * 25'(rgb_in.red))
		+ 25'(GREY_WT_G * 25'(rgb_in.green))
		+ 25'(GREY_WT_B * 25'(rgb_in.blue));
	assign grey = sum[23:16];

	always_comb begin
		if (enable) begin
			rgb_out = '{red: grey, green: grey, blue: grey};
		end else begin
			rgb_out = rgb_in;
		end
	end

endmodule

[hw/rtl/obd_cmp.sv]
// Threshold compare of one colour channel against a Bayer entry.
// Depends on obd_pkg for the threshold struct.
module obd_cmp
	import obd_pkg::*;
(
	input  logic [7:0] value,
	input  thr_t       thr,
	output logic [7:0] level
);

	logic [13:0] lhs;
	logic [13:0] rhs;

	// value * maxEntry > entry * 255 is the exact form of the normalized compare.
	assign lhs   = 14'(value) * 14'(thr.max_entry);
	assign rhs   = 14'(thr.entry) * 14'd255;
	assign level = (lhs > rhs) ? 8'd255 : 8'd0;

endmodule
